[sv/closed_loop_stepper_pid_assert.svh]
// Assertion macros shared by the stepper servo RTL.
`ifndef CLOSED_LOOP_STEPPER_PID_ASSERT_SVH
`define CLOSED_LOOP_STEPPER_PID_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define CLSP_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");

// Implication that must hold at every clock edge, also during reset.
`define CLSP_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) else $error("assertion failed");

`endif

[sv/clsp_pkg.sv]
`default_nettype none
package clsp_pkg;
    typedef struct packed {
        logic [15:0] step_count;
        logic [13:0] rotor_angle;
    } clsp_in_t;

    typedef struct packed {
        logic signed [31:0] drive_position;
        logic [11:0]        drive_current;
        logic               current_limited;
    } clsp_out_t;

    localparam int IntegralLimit = 65536;
    localparam int FilterKeep    = 125;
    localparam int FilterGain    = 3;
    localparam int HoldTime      = 1000;

    localparam logic [2:0] RegEnable     = 3'd0;
    localparam logic [2:0] RegClosedLoop = 3'd1;
    localparam logic [2:0] RegStepSize   = 3'd2;
    localparam logic [2:0] RegGainP      = 3'd3;
    localparam logic [2:0] RegGainI      = 3'd4;
    localparam logic [2:0] RegGainD      = 3'd5;
    localparam logic [2:0] RegCurLimit   = 3'd6;
    localparam logic [2:0] RegOpenCur    = 3'd7;

    // Width of a wide accumulator; the serial multiplier sizes its own without it.
    localparam int AccW = 64;
endpackage
`default_nettype wire

[sv/closed_loop_stepper_pid.sv]
// Closed-loop stepper servo tick. Each accepted item carries a step-pulse
// count and a calibrated rotor angle; while enabled, one result item follows
// per input item, and none while disabled. The block handles one item at a
// time. A closed-loop item's time is set by the bit-serial multiplier, which
// is shared by the four products of the control law and used one product
// after another. An open-loop item needs no product. Signed divisions by
// the constant powers of two truncate toward zero by a bias before the
// shift. A finished result sits in an output register. The next item may
// be accepted while that result waits; it is worked through, and then holds
// in its last step without touching the output register or the servo state
// that the last step writes until the waiting result has gone, so a stalled
// receiver stalls the input in turn. Configuration is written through the
// APB port only while the block is idle; the user must keep to this, as the
// block itself does not enforce it.
`default_nettype none
module closed_loop_stepper_pid #(
    parameter int INTEGRAL_LIMIT = clsp_pkg::IntegralLimit,
    parameter int FILTER_KEEP    = clsp_pkg::FilterKeep,
    parameter int FILTER_GAIN    = clsp_pkg::FilterGain,
    parameter int HOLD_TIME      = clsp_pkg::HoldTime
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire clsp_pkg::clsp_in_t s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output clsp_pkg::clsp_out_t     m_data,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import clsp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_UNWRAP, S_MUL_I, S_WAIT_I, S_MUL_K, S_WAIT_K,
        S_MUL_D, S_WAIT_D, S_MUL_P, S_WAIT_P, S_FINISH, S_OPEN
    } state_t;

    // Configuration registers.
    logic        enable_reg, closed_reg;
    logic [7:0]  step_size_reg;
    logic [11:0] gain_p_reg, gain_i_reg, gain_d_reg, cur_limit_reg, open_cur_reg;

    // Servo state.
    logic [15:0]        last_step_reg;
    logic [31:0]        step_base_reg;
    logic [13:0]        last_angle_reg;
    logic [15:0]        turn_reg;
    logic signed [31:0] last_pos_reg, integ_reg, dfilt_reg, last_target_reg;
    logic [9:0]         hold_reg;

    // Per-item working registers.
    state_t             state_reg;
    clsp_in_t           in_reg;
    logic [31:0]        target_reg;
    logic signed [31:0] yw_reg;
    logic signed [11:0] err_reg;
    logic signed [33:0] dpos_reg;
    logic signed [47:0] t_reg;
    logic signed [47:0] df_reg;
    logic signed [47:0] it_reg;
    clsp_out_t          out_reg;
    logic               out_valid_reg;

    // Shared multiplier.
    logic               mul_start;
    logic signed [47:0] mul_a;
    logic [15:0]        mul_b;
    logic               mul_done;
    logic signed [63:0] mul_p;

    clsp_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .mcand   (mul_a),
        .mplier  (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    logic in_fire, out_fire, cfg_wr, out_load;
    assign in_fire  = s_valid && s_ready;
    assign out_fire = m_valid && m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    // A finished item may load the output register once it is free or is
    // being emptied at this very edge.
    assign out_load = ((state_reg == S_FINISH) || (state_reg == S_OPEN))
                      && (!out_valid_reg || out_fire);

    always_comb begin
        unique case (paddr[4:2])
            RegEnable:     prdata = {31'd0, enable_reg};
            RegClosedLoop: prdata = {31'd0, closed_reg};
            RegStepSize:   prdata = {24'd0, step_size_reg};
            RegGainP:      prdata = {20'd0, gain_p_reg};
            RegGainI:      prdata = {20'd0, gain_i_reg};
            RegGainD:      prdata = {20'd0, gain_d_reg};
            RegCurLimit:   prdata = {20'd0, cur_limit_reg};
            RegOpenCur:    prdata = {20'd0, open_cur_reg};
            default:       prdata = '0;
        endcase
    end

    // Signed truncating shift right (division by 2^k toward zero).
    function automatic logic signed [63:0] sdiv(input logic signed [63:0] v, input int k);
        logic signed [63:0] b;
        b = v + ((v < 0) ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0);
        return b >>> k;
    endfunction

    // Combinational helpers for the unwrap step.
    logic signed [16:0] ds;
    logic [31:0]        inc, base_new, tgt_new;
    logic signed [14:0] dy;
    logic [15:0]        turn_new;
    logic signed [31:0] yw_new;
    logic signed [33:0] ediff;
    logic signed [11:0] e_new;
    always_comb begin
        ds  = 17'(signed'({1'b0, in_reg.step_count})) - 17'(signed'({1'b0, last_step_reg}));
        inc = {8'd0, step_size_reg, 16'd0};
        base_new = step_base_reg;
        if (ds < -17'sd32768) begin
            base_new = step_base_reg + inc;
        end else if (ds > 17'sd32768) begin
            base_new = step_base_reg - inc;
        end
        tgt_new = base_new + 32'(step_size_reg) * 32'(in_reg.step_count);
        dy = 15'(signed'({1'b0, in_reg.rotor_angle})) - 15'(signed'({1'b0, last_angle_reg}));
        turn_new = turn_reg;
        if (dy > 15'sd8192) begin
            turn_new = turn_reg - 16'd1;
        end else if (dy < -15'sd8192) begin
            turn_new = turn_reg + 16'd1;
        end
        // The turn count is signed, so its scaled value is sign-extended.
        yw_new = 32'(signed'({1'b0, in_reg.rotor_angle}))
               + 32'(signed'({turn_new, 14'd0}));
        ediff = 34'(signed'(tgt_new)) - 34'(yw_new);
        if (ediff > 34'sd1638) begin
            e_new = 12'sd1638;
        end else if (ediff < -34'sd1638) begin
            e_new = -12'sd1638;
        end else begin
            e_new = ediff[11:0];
        end
    end

    // Derived closing values.
    logic signed [63:0] u_full, adv_full, pos_full, u_abs;
    logic signed [63:0] adv_c;
    always_comb begin
        u_full   = sdiv(64'(mul_p) + 64'(it_reg) + 64'(df_reg), 7);
        adv_full = sdiv(64'(dpos_reg) * 64'sd3, 1);
        pos_full = 64'(signed'({1'b0, in_reg.rotor_angle}));
        u_abs    = u_full;
        adv_c    = '0;
        if (u_full > 0) begin
            adv_c = (adv_full < 0) ? 64'sd0 : ((adv_full > 64'sd68) ? 64'sd68 : adv_full);
            pos_full = pos_full + 64'sd82 + adv_c;
        end else if (u_full < 0) begin
            adv_c = (adv_full > 0) ? 64'sd0 : ((adv_full < -64'sd68) ? -64'sd68 : adv_full);
            pos_full = pos_full - (64'sd82 - adv_c);
            u_abs = -u_full;
        end
    end

    always_comb begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        unique case (state_reg)
            S_MUL_I: begin
                mul_start = 1'b1;
                mul_a = 48'(err_reg);
                mul_b = 16'(gain_i_reg);
            end
            S_MUL_K: begin
                mul_start = 1'b1;
                mul_a = 48'(dfilt_reg);
                mul_b = 16'(FILTER_KEEP);
            end
            S_MUL_D: begin
                mul_start = 1'b1;
                mul_a = 48'(dpos_reg) * 48'(FILTER_GAIN);
                mul_b = 16'(gain_d_reg);
            end
            S_MUL_P: begin
                mul_start = 1'b1;
                mul_a = 48'(err_reg);
                mul_b = 16'(gain_p_reg);
            end
            default: begin
                mul_start = 1'b0;
            end
        endcase
    end

    logic signed [63:0] it_sum, df_sum, t_div;
    logic [9:0]         hold_new;
    assign it_sum = 64'(integ_reg) + sdiv(mul_p, 5);
    assign df_sum = 64'(t_reg) - sdiv(mul_p, 3);
    assign t_div  = sdiv(mul_p, 7);
    always_comb begin
        if (target_reg == last_target_reg) begin
            hold_new = (32'(hold_reg) + 32'd1 >= 32'(HOLD_TIME)) ? 10'(HOLD_TIME)
                                                                  : hold_reg + 10'd1;
        end else begin
            hold_new = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            out_valid_reg   <= 1'b0;
            enable_reg      <= 1'b0;
            closed_reg      <= 1'b1;
            step_size_reg   <= 8'd1;
            gain_p_reg      <= '0;
            gain_i_reg      <= '0;
            gain_d_reg      <= '0;
            cur_limit_reg   <= '0;
            open_cur_reg    <= '0;
            last_step_reg   <= '0;
            step_base_reg   <= '0;
            last_angle_reg  <= '0;
            turn_reg        <= '0;
            last_pos_reg    <= '0;
            integ_reg       <= '0;
            dfilt_reg       <= '0;
            last_target_reg <= '0;
            hold_reg        <= '0;
        end else begin
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_fire) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr) begin
                unique case (paddr[4:2])
                    RegEnable:     enable_reg    <= pwdata[0];
                    RegClosedLoop: closed_reg    <= pwdata[0];
                    RegStepSize:   step_size_reg <= pwdata[7:0];
                    RegGainP:      gain_p_reg    <= pwdata[11:0];
                    RegGainI:      gain_i_reg    <= pwdata[11:0];
                    RegGainD:      gain_d_reg    <= pwdata[11:0];
                    RegCurLimit:   cur_limit_reg <= pwdata[11:0];
                    RegOpenCur:    open_cur_reg  <= pwdata[11:0];
                    default:       enable_reg    <= enable_reg;
                endcase
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (in_fire) begin
                        in_reg    <= s_data;
                        state_reg <= enable_reg ? S_UNWRAP : S_IDLE;
                    end
                end
                S_UNWRAP: begin
                    step_base_reg <= base_new;
                    last_step_reg <= in_reg.step_count;
                    target_reg    <= tgt_new;
                    if (closed_reg) begin
                        turn_reg  <= turn_new;
                        yw_reg    <= yw_new;
                        err_reg   <= e_new;
                        dpos_reg  <= 34'(yw_new) - 34'(last_pos_reg);
                        state_reg <= S_MUL_I;
                    end else begin
                        state_reg <= S_OPEN;
                    end
                end
                S_MUL_I: state_reg <= S_WAIT_I;
                S_WAIT_I: begin
                    if (mul_done) begin
                        if (it_sum > 64'(INTEGRAL_LIMIT)) begin
                            it_reg <= 48'(INTEGRAL_LIMIT);
                        end else if (it_sum < -64'(INTEGRAL_LIMIT)) begin
                            it_reg <= -48'(INTEGRAL_LIMIT);
                        end else begin
                            it_reg <= it_sum[47:0];
                        end
                        state_reg <= S_MUL_K;
                    end
                end
                S_MUL_K: state_reg <= S_WAIT_K;
                S_WAIT_K: begin
                    if (mul_done) begin
                        t_reg     <= t_div[47:0];
                        state_reg <= S_MUL_D;
                    end
                end
                S_MUL_D: state_reg <= S_WAIT_D;
                S_WAIT_D: begin
                    if (mul_done) begin
                        if (df_sum > 64'sd2147483647) begin
                            df_reg <= 48'sd2147483647;
                        end else if (df_sum < -64'sd2147483648) begin
                            df_reg <= -48'sd2147483648;
                        end else begin
                            df_reg <= df_sum[47:0];
                        end
                        state_reg <= S_MUL_P;
                    end
                end
                S_MUL_P: begin
                    integ_reg <= it_reg[31:0];
                    dfilt_reg <= df_reg[31:0];
                    state_reg <= S_WAIT_P;
                end
                S_WAIT_P: begin
                    if (mul_done) begin
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    // Hold here while the previous result still waits.
                    if (out_load) begin
                        last_angle_reg              <= in_reg.rotor_angle;
                        last_pos_reg                <= yw_reg;
                        out_reg.drive_position      <= pos_full[31:0];
                        if (u_abs > 64'(cur_limit_reg)) begin
                            out_reg.drive_current   <= cur_limit_reg;
                            out_reg.current_limited <= 1'b1;
                        end else begin
                            out_reg.drive_current   <= u_abs[11:0];
                            out_reg.current_limited <= 1'b0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                S_OPEN: begin
                    if (out_load) begin
                        hold_reg               <= hold_new;
                        last_target_reg        <= target_reg;
                        out_reg.drive_position <= target_reg;
                        out_reg.drive_current  <= (32'(hold_new) >= 32'(HOLD_TIME))
                                                  ? (open_cur_reg >> 1) : open_cur_reg;
                        out_reg.current_limited <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `include "closed_loop_stepper_pid_assert.svh"
    `CLSP_ASSERT(a_ready_idle, aclk, aresetn, s_ready |-> (state_reg == S_IDLE))
    `CLSP_ASSERT(a_disabled_quiet, aclk, aresetn,
        (in_fire && !enable_reg) |=> (state_reg == S_IDLE))
    `CLSP_ASSERT(a_open_no_flag, aclk, aresetn,
        (state_reg == S_OPEN && out_load) |=> !out_reg.current_limited)
endmodule
`default_nettype wire

[sv/clsp_mul.sv]
`default_nettype none
// Bit-serial signed multiplier: signed 48-bit multiplicand by an unsigned
// 16-bit multiplier, one multiplier bit per cycle, shift-and-add.
module clsp_mul (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic signed [47:0]   mcand,
    input  wire logic [15:0]          mplier,
    output logic                      done,
    output logic signed [63:0]        product
);
    import clsp_pkg::*;

    logic signed [63:0] acc_reg, acc_next;
    logic signed [63:0] mc_reg, mc_next;
    logic [15:0]        mp_reg, mp_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;

    always_comb begin
        acc_next  = acc_reg;
        mc_next   = mc_reg;
        mp_next   = mp_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            acc_next  = '0;
            mc_next   = 64'(mcand);
            mp_next   = mplier;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (mp_reg[0]) begin
                acc_next = acc_reg + mc_reg;
            end
            mc_next  = mc_reg <<< 1;
            mp_next  = mp_reg >> 1;
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd15) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        acc_reg <= acc_next;
        mc_reg  <= mc_next;
        mp_reg  <= mp_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

    `include "closed_loop_stepper_pid_assert.svh"
    `CLSP_ASSERT(a_mul_done_once, aclk, aresetn, done_reg |=> !done_reg)
    `CLSP_ASSERT(a_mul_start_idle, aclk, aresetn, start |-> !busy_reg)
    `CLSP_ASSERT(a_mul_cnt, aclk, aresetn, !busy_reg |-> (cnt_reg == 5'd0 || cnt_reg == 5'd16))
endmodule
`default_nettype wire

[tb/sv/closed_loop_stepper_pid_tb.sv]
`default_nettype none
// Testbench for the closed-loop stepper servo tick.
// A queue of pending items, filled by the stimulus process, feeds a clocked driver.
// A clocked monitor compares each result item with the oldest prediction.
// The predictor follows the control law at the block's widths, with its own copy of
// the servo state and of the registers. Register writes go through the APB port,
// and only while the block is idle.
module closed_loop_stepper_pid_tb;
    import clsp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    clsp_in_t    s_data;
    logic        m_valid;
    logic        m_ready;
    clsp_out_t   m_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    closed_loop_stepper_pid u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Shadow copy of the registers, kept in step with every APB write.
    logic        cfg_enable;
    logic        cfg_closed;
    logic [7:0]  cfg_step;
    logic [11:0] cfg_kp, cfg_ki, cfg_kd, cfg_ilim, cfg_iopen;

    // Servo state as the predictor sees it.
    logic [15:0] st_last_steps;
    logic [31:0] st_step_base;
    logic [13:0] st_last_angle;
    logic [15:0] st_turns;
    logic [31:0] st_last_pos;
    logic [31:0] st_integ;
    logic [31:0] st_dfilt;
    logic [31:0] st_last_target;
    logic [9:0]  st_hold;

    clsp_in_t  tick_queue[$];
    clsp_out_t drive_expected[$];

    int  errors;
    int  cycle;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  sending_done;

    // Limit on the whole run. It leaves room for the closed-loop items, which
    // wait on the serial multiplier, and for the phases in which the sender
    // idles or the receiver stalls.
    localparam int CycleLimit = 2_000_000;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic longint clamp(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // One control tick. SystemVerilog division of signed longints truncates
    // towards zero, just as the law requires. The state advances as the
    // block's own does, and the result is queued when the drive is enabled.
    task automatic predict_tick(input clsp_in_t t);
        longint    d, yw, e, it, df, dpos, u, adv, pos;
        logic [31:0] inc, target;
        clsp_out_t res;
        if (!cfg_enable) return;
        d = longint'(t.step_count) - longint'(st_last_steps);
        inc = {8'd0, cfg_step, 16'd0};
        if (d < -32768) st_step_base = st_step_base + inc;
        else if (d > 32768) st_step_base = st_step_base - inc;
        st_last_steps = t.step_count;
        target = st_step_base + 32'(cfg_step) * 32'(t.step_count);
        res = '0;
        if (cfg_closed) begin
            d = longint'(t.rotor_angle) - longint'(st_last_angle);
            if (d > 8192) st_turns = st_turns - 16'd1;
            else if (d < -8192) st_turns = st_turns + 16'd1;
            yw = longint'(t.rotor_angle) + 16384 * longint'($signed(st_turns));
            e = clamp(longint'($signed(target)) - yw, -1638, 1638);
            it = longint'($signed(st_integ)) + (longint'(cfg_ki) * e) / 32;
            it = clamp(it, -IntegralLimit, IntegralLimit);
            st_integ = 32'(it);
            dpos = yw - longint'($signed(st_last_pos));
            df = (longint'(FilterKeep) * longint'($signed(st_dfilt))) / 128
               - (longint'(FilterGain) * longint'(cfg_kd) * dpos) / 8;
            df = clamp(df, -64'sd2147483648, 64'sd2147483647);
            st_dfilt = 32'(df);
            u = (longint'(cfg_kp) * e + it + df) / 128;
            adv = (3 * dpos) / 2;
            st_last_angle = t.rotor_angle;
            st_last_pos = 32'(yw);
            pos = longint'(t.rotor_angle);
            if (u > 0) begin
                pos += 82 + clamp(adv, 0, 68);
            end else if (u < 0) begin
                pos -= 82 - clamp(adv, -68, 0);
                u = -u;
            end
            res.drive_position = 32'(pos);
            if (u > longint'(cfg_ilim)) begin
                res.drive_current = cfg_ilim;
                res.current_limited = 1'b1;
            end else begin
                res.drive_current = 12'(u);
            end
        end else begin
            if (target == st_last_target) begin
                if (st_hold < 10'(HoldTime)) st_hold = st_hold + 10'd1;
            end else begin
                st_hold = '0;
            end
            res.drive_position = target;
            res.drive_current = (st_hold >= 10'(HoldTime)) ? cfg_iopen >> 1 : cfg_iopen;
            st_last_target = target;
        end
        drive_expected.push_back(res);
    endtask

    // Driver: takes the next pending item once the previous one has gone,
    // with random gaps when the sender is set to idle. The item on the port
    // stays at the front of the queue until it is accepted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data  <= '0;
        end else begin
            if (s_valid && s_ready) begin
                predict_tick(s_data);
                void'(tick_queue.pop_front());
            end
            if ((!s_valid || s_ready) && tick_queue.size() > 0
                    && $urandom_range(99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data  <= tick_queue[0];
            end else if (!s_valid || s_ready) begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks every accepted result item against the oldest prediction.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (drive_expected.size() == 0) begin
                    $display("%0t: unexpected result, actual %p", $time, m_data);
                    errors++;
                end else begin
                    clsp_out_t want;
                    want = drive_expected.pop_front();
                    if (m_data.drive_position !== want.drive_position) begin
                        $display("%0t: drive_position expected %0d actual %0d",
                                 $time, want.drive_position, m_data.drive_position);
                        errors++;
                    end
                    if (m_data.drive_current !== want.drive_current) begin
                        $display("%0t: drive_current expected %0d actual %0d",
                                 $time, want.drive_current, m_data.drive_current);
                        errors++;
                    end
                    if (m_data.current_limited !== want.current_limited) begin
                        $display("%0t: current_limited expected %0b actual %0b",
                                 $time, want.current_limited, m_data.current_limited);
                        errors++;
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // The cycle counter guards against a hung block.
    always @(posedge aclk) begin
        cycle <= cycle + 1;
        if (cycle > CycleLimit) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // An APB write: setup cycle, then access cycle. pready is always high, so
    // the write lands at the edge closing the access cycle. The shadow copy is
    // updated at once, since the block is idle while this happens.
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            RegEnable:     cfg_enable = val[0];
            RegClosedLoop: cfg_closed = val[0];
            RegStepSize:   cfg_step   = val[7:0];
            RegGainP:      cfg_kp     = val[11:0];
            RegGainI:      cfg_ki     = val[11:0];
            RegGainD:      cfg_kd     = val[11:0];
            RegCurLimit:   cfg_ilim   = val[11:0];
            default:       cfg_iopen  = val[11:0];
        endcase
    endtask

    // Waits until every pending item has gone in and every result has come
    // out, then lets the block finish any item that makes no result.
    task automatic drain();
        while (tick_queue.size() != 0 || s_valid || drive_expected.size() != 0)
            @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic configure(input bit en, input bit cl, input logic [7:0] ss,
                             input logic [11:0] kp, input logic [11:0] ki,
                             input logic [11:0] kd, input logic [11:0] lim,
                             input logic [11:0] oc);
        reg_write(RegEnable, {$urandom} & ~32'h1 | 32'(en));
        reg_write(RegClosedLoop, 32'(cl));
        reg_write(RegStepSize, 32'(ss));
        reg_write(RegGainP, 32'(kp));
        reg_write(RegGainI, 32'(ki));
        reg_write(RegGainD, 32'(kd));
        reg_write(RegCurLimit, 32'(lim));
        reg_write(RegOpenCur, 32'(oc));
    endtask

    function automatic clsp_in_t mk(int sc, int ang);
        clsp_in_t t;
        t.step_count  = 16'(sc);
        t.rotor_angle = 14'(ang);
        return t;
    endfunction

    // A run of random items. Most follow a plausible motion: the step count
    // and angle drift by small amounts and wrap naturally; the rest jump
    // anywhere, so that both unwraps and every field bit are exercised.
    task automatic random_burst(input int n);
        int sc, ang;
        sc  = $urandom_range(65535);
        ang = $urandom_range(16383);
        repeat (n) begin
            if ($urandom_range(9) < 8) begin
                sc  = (sc + $urandom_range(400) - 200) & 16'hFFFF;
                ang = (ang + $urandom_range(600) - 300) & 14'h3FFF;
            end else begin
                sc  = $urandom_range(65535);
                ang = $urandom_range(16383);
            end
            tick_queue.push_back(mk(sc, ang));
        end
    endtask

    initial begin
        int sc;
        errors = 0;
        cycle = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        aresetn = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        cfg_enable = 1'b0; cfg_closed = 1'b1; cfg_step = 8'd1;
        cfg_kp = '0; cfg_ki = '0; cfg_kd = '0; cfg_ilim = '0; cfg_iopen = '0;
        st_last_steps = '0; st_step_base = '0; st_last_angle = '0; st_turns = '0;
        st_last_pos = '0; st_integ = '0; st_dfilt = '0; st_last_target = '0;
        st_hold = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Disabled ticks first: nothing may come out of them.
        tick_queue.push_back(mk(16'hFFFF, 14'h3FFF));
        tick_queue.push_back(mk(0, 0));
        drain();

        // Closed loop at the largest gains: the error clamp, the integral
        // clamp, the filter extremes and the angle wrapping both ways.
        configure(1, 1, 8'd255, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
        tick_queue.push_back(mk(16'hFFFF, 14'h3FFF));
        tick_queue.push_back(mk(0, 0));
        tick_queue.push_back(mk(16'hFFFF, 14'h3FFF));
        tick_queue.push_back(mk(16'h8000, 14'h2000));
        tick_queue.push_back(mk(0, 0));
        tick_queue.push_back(mk(16'h7FFF, 14'h1FFF));
        tick_queue.push_back(mk(16'h0100, 14'h3FFF));
        tick_queue.push_back(mk(16'h0100, 14'h0000));
        drain();

        // Zero current limit, so the cap is met whenever the drive current is nonzero.
        configure(1, 1, 8'd0, 12'd1, 12'd0, 12'd0, 12'd0, 12'd0);
        tick_queue.push_back(mk(5, 100));
        tick_queue.push_back(mk(5, 16000));
        tick_queue.push_back(mk(5, 200));
        drain();

        // Open loop: a held target must halve the current after the hold time.
        configure(1, 0, 8'd3, 12'd0, 12'd0, 12'd0, 12'd0, 12'hFFF);
        for (int i = 0; i < 1005; i++) tick_queue.push_back(mk(42, i));
        tick_queue.push_back(mk(43, 0));
        tick_queue.push_back(mk(16'hFFFF, 0));
        tick_queue.push_back(mk(0, 0));
        drain();

        // Random phases, each under a fresh setting and idling pattern.
        for (int ph = 0; ph < 16; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            configure(ph != 7, (ph % 3) != 2, 8'($urandom_range(255)),
                      12'($urandom), 12'($urandom), 12'($urandom),
                      12'($urandom), 12'($urandom));
            random_burst(17);
            // Pause the sender until the block has caught up.
            while (drive_expected.size() != 0 || tick_queue.size() != 0 || s_valid)
                @(posedge aclk);
            random_burst(17);
            drain();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();

        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
`default_nettype wire
